[sv/stbs_pkg.sv]
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and codes for the sorted table bisection search block:
// channel item layouts, operation codes, search sequencer states and the
// result bundle passed from the search engine to the top level.
// ----------------------------------------------------------------------------
package stbs_pkg;

   // operation codes carried in the request item
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // request item: table write or key lookup
   typedef struct packed {
      logic       operation;
      logic [6:0] entry_index;
      logic [7:0] key_value;
   } req_item_type;

   // response item: lookup result
   typedef struct packed {
      logic       found;
      logic [6:0] match_index;
   } rsp_item_type;

   // search sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CHK_LO,
      ST_CHK_HI,
      ST_RESULT
   } search_state_type;

   // finished lookup offered by the engine
   typedef struct packed {
      logic       valid;
      logic       found;
      logic [6:0] match_index;
   } search_result_type;

endpackage

[sv/stbs_engine.sv]
// ----------------------------------------------------------------------------
// stbs_engine
// Bisection search sequencer. One equal compare, one greater compare and the
// bisection step are reused every cycle; the table read address for the next
// probe is formed from the current compare so one probe completes per clock.
// ----------------------------------------------------------------------------
module stbs_engine #(
   parameter int MAX_ENTRIES = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [7:0]                           key,
   input  logic [7:0]                           entry_count,
   input  logic [7:0]                           rd_data,
   input  logic                                 take,
   output logic [$clog2(MAX_ENTRIES)-1:0]       rd_addr,
   output logic                                 idle,
   output stbs_pkg::search_result_type          result
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CW    = (IDX_W > 8) ? IDX_W : 8;
   localparam int NW    = ((IDX_W + 1) > 8) ? (IDX_W + 1) : 8;
   localparam int MW    = (IDX_W > 7) ? IDX_W : 7;

   stbs_pkg::search_state_type state_ff, state_in;
   logic [IDX_W-1:0] lo_ff, lo_in;
   logic [IDX_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [7:0]       key_ff, key_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] index_ff, index_in;

   logic [NW-1:0]    cnt_w;
   logic [NW-1:0]    n_w;
   logic [IDX_W-1:0] hi_init;
   logic [CW-1:0]    key_m1_w;
   logic [IDX_W-1:0] cur_init;
   logic             hit;
   logic             go_up;
   logic [IDX_W-1:0] lo_n, hi_n, cur_n;
   logic [MW-1:0]    index_w;

   // clamp the entry count and find the first probe position
   always_comb begin
      cnt_w    = NW'(entry_count);
      n_w      = (cnt_w > NW'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : cnt_w;
      hi_init  = IDX_W'(n_w - NW'(1));
      key_m1_w = CW'(key) - CW'(1);
      if ((key == 8'd0) || (key_m1_w > CW'(hi_init))) begin
         cur_init = hi_init;
      end else begin
         cur_init = key_m1_w[IDX_W-1:0];
      end
   end

   // shared compare and bisection step
   always_comb begin
      hit   = (rd_data == key_ff);
      go_up = (key_ff > rd_data);
      if (go_up) begin
         lo_n  = cur_ff;
         hi_n  = hi_ff;
         cur_n = cur_ff + ((hi_ff - cur_ff) >> 1);
      end else begin
         lo_n  = lo_ff;
         hi_n  = cur_ff;
         cur_n = cur_ff - ((cur_ff - lo_ff) >> 1);
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      cur_in   = cur_ff;
      key_in   = key_ff;
      found_in = found_ff;
      index_in = index_ff;
      rd_addr  = cur_ff;
      unique case (state_ff)
         stbs_pkg::ST_IDLE: begin
            if (start) begin
               key_in = key;
               lo_in  = '0;
               hi_in  = hi_init;
               cur_in = cur_init;
               if (n_w == '0) begin
                  found_in = 1'b0;
                  index_in = '0;
                  state_in = stbs_pkg::ST_RESULT;
               end else if (hi_init > IDX_W'(1)) begin
                  rd_addr  = cur_init;
                  state_in = stbs_pkg::ST_PROBE;
               end else begin
                  rd_addr  = '0;
                  state_in = stbs_pkg::ST_CHK_LO;
               end
            end
         end
         stbs_pkg::ST_PROBE: begin
            if (hit) begin
               found_in = 1'b1;
               index_in = cur_ff;
               state_in = stbs_pkg::ST_RESULT;
            end else begin
               lo_in  = lo_n;
               hi_in  = hi_n;
               cur_in = cur_n;
               if ((hi_n - lo_n) > IDX_W'(1)) begin
                  rd_addr = cur_n;
               end else begin
                  rd_addr  = lo_n;
                  state_in = stbs_pkg::ST_CHK_LO;
               end
            end
         end
         stbs_pkg::ST_CHK_LO: begin
            if (hit) begin
               found_in = 1'b1;
               index_in = lo_ff;
               state_in = stbs_pkg::ST_RESULT;
            end else begin
               rd_addr  = hi_ff;
               state_in = stbs_pkg::ST_CHK_HI;
            end
         end
         stbs_pkg::ST_CHK_HI: begin
            found_in = hit;
            index_in = hit ? hi_ff : '0;
            state_in = stbs_pkg::ST_RESULT;
         end
         stbs_pkg::ST_RESULT: begin
            if (take) begin
               state_in = stbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stbs_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // search bounds and result registers
   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      cur_ff   <= cur_in;
      key_ff   <= key_in;
      found_ff <= found_in;
      index_ff <= index_in;
   end

   // status to the top level
   always_comb begin
      index_w            = MW'(index_ff);
      idle               = (state_ff == stbs_pkg::ST_IDLE);
      result.valid       = (state_ff == stbs_pkg::ST_RESULT);
      result.found       = found_ff;
      result.match_index = index_w[6:0];
   end

endmodule

[sv/sorted_table_bisection_search_top.sv]
// ----------------------------------------------------------------------------
// sorted_table_bisection_search_top
// Sorted key table with bisection lookup. A write item stores one 8-bit key
// at a table position and gives no response. A lookup item searches the
// first entry_count positions (clamped to MAX_ENTRIES), which software keeps
// in ascending order, and returns one response with a found flag and the
// matching position (0 when not found). A lookup holds the request side
// stalled while it runs, with one table read per cycle through the single
// memory read port. The first probe can land anywhere in the range, and
// after it each probe about halves the span, so a 128-entry table takes 1 to
// 8 probes. Then come up to two bound checks and the handoff of the response
// to the output register. The request side stays stalled until that handoff,
// also while an earlier response waits under stall. The response is offered
// in the cycle after the handoff. An empty table answers not found without
// probing the table. Entries must be written before a lookup can probe them;
// the table has no reset.
// ----------------------------------------------------------------------------
module sorted_table_bisection_search_top #(
   parameter int MAX_ENTRIES = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  stbs_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output stbs_pkg::rsp_item_type rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_entry_count
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int PW    = (IDX_W > 7) ? IDX_W : 7;

   logic [7:0]       entry_count_ff;
   logic [7:0]       key_table [MAX_ENTRIES];
   logic [7:0]       rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic [PW:0]      pos_w;
   logic             wr_en;
   logic             req_take;
   logic             lookup_start;
   logic             eng_idle;
   logic             res_take;
   logic             rsp_valid_ff, rsp_valid_in;
   stbs_pkg::rsp_item_type     rsp_item_ff;
   stbs_pkg::search_result_type eng_result;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= 8'd0;
      end else if (csr_valid && csr_ready) begin
         entry_count_ff <= csr_entry_count;
      end
   end

   // request decode
   always_comb begin
      req_stall    = !eng_idle;
      req_take     = req_valid && !req_stall;
      pos_w        = (PW + 1)'(req_item.entry_index);
      wr_en        = req_take && (req_item.operation == stbs_pkg::OP_WRITE)
                     && (pos_w < (PW + 1)'(MAX_ENTRIES));
      lookup_start = req_take && (req_item.operation == stbs_pkg::OP_LOOKUP);
   end

   // key table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_table[pos_w[IDX_W-1:0]] <= req_item.key_value;
      end
      rd_data_ff <= key_table[rd_addr];
   end

   // search sequencer
   stbs_engine #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (lookup_start),
      .key         (req_item.key_value),
      .entry_count (entry_count_ff),
      .rd_data     (rd_data_ff),
      .take        (res_take),
      .rd_addr     (rd_addr),
      .idle        (eng_idle),
      .result      (eng_result)
   );

   // response output register
   always_comb begin
      res_take = eng_result.valid && (!rsp_valid_ff || !rsp_stall);
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_item_ff.found       <= eng_result.found;
         rsp_item_ff.match_index <= eng_result.match_index;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // a lookup keeps the request side stalled on the following cycle
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      lookup_start |=> req_stall)
      else $error("lookup accepted but request side not stalled");

   // a write never produces a response
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_item.operation == stbs_pkg::OP_WRITE)) |=> !eng_result.valid)
      else $error("write item produced a result");

   // a miss reports position zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.found) |-> (rsp_item.match_index == 7'd0))
      else $error("not found response with nonzero index");

   // a new response only appears from a finished search
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(eng_result.valid))
      else $error("response without finished search");

endmodule

[test/tb_sorted_table_bisection_search_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_table_bisection_search_top
// Self-checking bench for the sorted key table search block. A shadow copy of
// the table and the entry count feeds a bisection predictor. Each accepted
// lookup queues its expected response, and a checker compares every response
// with the oldest one. Stimulus runs in this order: empty table lookups, a
// sorted table fill, directed edge cases, then random phases of sorted
// rewrites and lookups. Random gaps and stalls hit both channels.
// ----------------------------------------------------------------------------
module tb_sorted_table_bisection_search_top;

   localparam int TABLE_DEPTH   = 128;
   localparam int SETTLE_CYCLES = 20;
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_ITEMS  = 870;

   logic                   clock;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_stall;
   stbs_pkg::req_item_type req_item        = '0;
   logic                   rsp_valid;
   logic                   rsp_stall       = 1'b0;
   stbs_pkg::rsp_item_type rsp_item;
   logic                   csr_valid       = 1'b0;
   logic                   csr_ready;
   logic [7:0]             csr_entry_count = 8'd0;

   // shadow of the block state
   logic [7:0]   shadow_keys [TABLE_DEPTH];
   logic [7:0]   shadow_count = 8'd0;

   // expected lookup responses, oldest first
   stbs_pkg::rsp_item_type pending_lookups [$];

   bit req_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;
   int failures    = 0;
   int writes_sent = 0;
   int lookups_sent = 0;
   int hits_seen   = 0;
   int count_writes = 0;
   int random_sent = 0;

   sorted_table_bisection_search_top #(
      .MAX_ENTRIES(TABLE_DEPTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item        (rsp_item),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_entry_count (csr_entry_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // gap length: mostly none, often short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // bisection search over the shadow table
   function automatic stbs_pkg::rsp_item_type predict_lookup(input logic [7:0] key);
      int unsigned n, lo, hi, cur, probed, kv;
      stbs_pkg::rsp_item_type r;
      r = '0;
      n = shadow_count;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      if (n == 0) return r;
      kv = key;
      lo = 0;
      hi = n - 1;
      cur = (kv == 0 || kv - 1 > hi) ? hi : kv - 1;
      while (hi > lo + 1) begin
         probed = shadow_keys[cur];
         if (probed == kv) begin
            r.found = 1'b1;
            r.match_index = cur[6:0];
            return r;
         end
         if (kv > probed) begin
            lo = cur;
            cur = cur + (hi - cur) / 2;
         end else begin
            hi = cur;
            cur = cur - (cur - lo) / 2;
         end
      end
      if (shadow_keys[lo] == kv) begin
         r.found = 1'b1;
         r.match_index = lo[6:0];
      end else if (shadow_keys[hi] == kv) begin
         r.found = 1'b1;
         r.match_index = hi[6:0];
      end
      return r;
   endfunction

   // response stall generator
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (rsp_idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      stbs_pkg::rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_lookups.size() == 0) begin
            $display("%0t: unexpected response found=%0b match_index=%0d",
                     $time, rsp_item.found, rsp_item.match_index);
            failures++;
         end else begin
            want = pending_lookups.pop_front();
            if (want.found) hits_seen++;
            if (rsp_item.found !== want.found) begin
               $display("%0t: found mismatch expected %0b actual %0b",
                        $time, want.found, rsp_item.found);
               failures++;
            end
            if (rsp_item.match_index !== want.match_index) begin
               $display("%0t: match_index mismatch expected %0d actual %0d",
                        $time, want.match_index, rsp_item.match_index);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_sorted_table_bisection_search_top NOT OK");
      $finish;
   end

   // send one item and update the shadow state once it is taken
   task automatic send_item(input logic op, input logic [6:0] idx, input logic [7:0] key);
      int gap;
      stbs_pkg::req_item_type it;
      gap = req_idle_on ? pick_gap() : 0;
      it.operation   = op;
      it.entry_index = idx;
      it.key_value   = key;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == stbs_pkg::OP_WRITE) begin
         shadow_keys[idx] = key;
         writes_sent++;
      end else begin
         pending_lookups.push_back(predict_lookup(key));
         lookups_sent++;
      end
   endtask

   // stop sending and wait for every queued response
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
   endtask

   // entry count write, only with the block idle
   task automatic set_entry_count(input logic [7:0] value);
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_entry_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_count = value;
      count_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // lookups on the empty table straight after reset
   task automatic test_empty_table();
      send_item(stbs_pkg::OP_LOOKUP, 7'd0, 8'd0);
      send_item(stbs_pkg::OP_LOOKUP, 7'd127, 8'd255);
      send_item(stbs_pkg::OP_LOOKUP, 7'd5, 8'd17);
   endtask

   // fill every position with odd keys in ascending order
   task automatic test_fill_table();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_item(stbs_pkg::OP_WRITE, i[6:0], 8'(2 * i + 1));
   endtask

   // extremes, key zero, count clamp, tiny counts and an unsorted table
   task automatic test_directed();
      set_entry_count(8'd128);
      send_item(stbs_pkg::OP_WRITE, 7'd0, 8'd0);
      send_item(stbs_pkg::OP_WRITE, 7'd127, 8'd255);
      send_item(stbs_pkg::OP_LOOKUP, 7'd0, 8'd0);
      send_item(stbs_pkg::OP_LOOKUP, 7'd127, 8'd255);
      send_item(stbs_pkg::OP_LOOKUP, 7'd0, 8'd1);
      send_item(stbs_pkg::OP_LOOKUP, 7'd0, 8'd3);
      send_item(stbs_pkg::OP_LOOKUP, 7'd0, 8'd128);
      send_item(stbs_pkg::OP_LOOKUP, 7'd0, 8'd129);
      send_item(stbs_pkg::OP_LOOKUP, 7'd0, 8'd254);
      set_entry_count(8'd1);
      send_item(stbs_pkg::OP_LOOKUP, 7'd0, 8'd0);
      send_item(stbs_pkg::OP_LOOKUP, 7'd0, 8'd3);
      set_entry_count(8'd2);
      send_item(stbs_pkg::OP_LOOKUP, 7'd0, 8'd3);
      send_item(stbs_pkg::OP_LOOKUP, 7'd0, 8'd0);
      send_item(stbs_pkg::OP_LOOKUP, 7'd0, 8'd255);
      set_entry_count(8'd255);
      send_item(stbs_pkg::OP_LOOKUP, 7'd0, 8'd255);
      send_item(stbs_pkg::OP_LOOKUP, 7'd0, 8'd0);
      set_entry_count(8'd200);
      send_item(stbs_pkg::OP_LOOKUP, 7'd0, 8'd201);
      set_entry_count(8'd0);
      send_item(stbs_pkg::OP_LOOKUP, 7'd0, 8'd0);
      // out-of-order key inside the searched range
      set_entry_count(8'd8);
      send_item(stbs_pkg::OP_WRITE, 7'd3, 8'd250);
      send_item(stbs_pkg::OP_LOOKUP, 7'd0, 8'd250);
      send_item(stbs_pkg::OP_LOOKUP, 7'd0, 8'd7);
   endtask

   // random phases: new count, sorted rewrite, lookups and some noise
   task automatic test_random_phases();
      int r, used, n_lookups, pick;
      logic [7:0] count, key;
      int unsigned level, step_max;
      while (random_sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 60)      count = 8'($urandom_range(1, 16));
         else if (r < 75) count = 8'($urandom_range(17, 127));
         else if (r < 90) count = 8'd128;
         else if (r < 95) count = 8'($urandom_range(129, 255));
         else             count = 8'd0;
         set_entry_count(count);
         used = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);

         // sorted rewrite of the searched range, duplicates allowed
         if ($urandom_range(0, 4) != 0) begin
            level = $urandom_range(0, 1) ? 0 : $urandom_range(0, 20);
            step_max = $urandom_range(0, 4);
            for (int i = 0; i < used; i++) begin
               send_item(stbs_pkg::OP_WRITE, i[6:0], level[7:0]);
               random_sent++;
               level = level + $urandom_range(0, step_max);
               if (level > 255) level = 255;
            end
         end
         if ($urandom_range(0, 9) == 0) begin
            send_item(stbs_pkg::OP_WRITE, 7'($urandom_range(0, 127)),
                      8'($urandom_range(0, 255)));
            random_sent++;
         end

         n_lookups = $urandom_range(15, 40);
         for (int j = 0; j < n_lookups; j++) begin
            pick = $urandom_range(0, 99);
            if (used > 0 && pick < 55) begin
               key = shadow_keys[$urandom_range(0, used - 1)];
            end else if (used > 0 && pick < 70) begin
               key = shadow_keys[$urandom_range(0, used - 1)];
               key = $urandom_range(0, 1) ? key + 8'd1 : key - 8'd1;
            end else begin
               key = 8'($urandom_range(0, 255));
            end
            if ($urandom_range(0, 19) == 0) begin
               send_item(stbs_pkg::OP_WRITE, 7'($urandom_range(0, 127)),
                         8'($urandom_range(0, 255)));
               random_sent++;
            end
            send_item(stbs_pkg::OP_LOOKUP, 7'($urandom_range(0, 127)), key);
            random_sent++;
            // hold the sender until all answers are back, now and then
            if (j == n_lookups / 2 && $urandom_range(0, 1) == 0) drain_responses();
         end
      end
   endtask

   // main sequence
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_fill_table();
      test_directed();
      test_random_phases();
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d table writes and %0d lookups (%0d hits)",
               writes_sent, lookups_sent, hits_seen);
      $display("across %0d entry count settings, including 0, 1, 128 and 255", count_writes);
      if (failures == 0 && pending_lookups.size() == 0) begin
         $display("tb_sorted_table_bisection_search_top OK");
      end else begin
         $display("tb_sorted_table_bisection_search_top NOT OK");
      end
      $finish;
   end

endmodule

[sim.f]
sv/stbs_pkg.sv
sv/stbs_engine.sv
sv/sorted_table_bisection_search_top.sv
test/tb_sorted_table_bisection_search_top.sv
